### sv/chacha20_stream_cipher_assert.svh
// Assertion macros shared by the cipher RTL.
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CC20_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CC20_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/cc20_pkg.sv
// Shared types and constants for the ChaCha20 stream cipher.
package cc20_pkg;

    localparam int CC20_DOUBLE_ROUNDS = 10;
    localparam int CC20_WORDS         = 16;

    typedef logic [31:0] word_t;

    localparam word_t SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    // configuration register indexes
    localparam logic [2:0] CFG_KEY01       = 3'd0;
    localparam logic [2:0] CFG_KEY23       = 3'd1;
    localparam logic [2:0] CFG_KEY45       = 3'd2;
    localparam logic [2:0] CFG_KEY67       = 3'd3;
    localparam logic [2:0] CFG_NONCE_FIRST = 3'd4;
    localparam logic [2:0] CFG_NONCE_UPPER = 3'd5;
    localparam logic [2:0] CFG_START_CTR   = 3'd6;

    typedef struct packed {
        logic load;
    } cc20_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cc20_stat_t;

endpackage

### sv/cc20_core.sv
// Block generator: one shared add-xor-rotate unit runs the rounds and feed-forward.
module cc20_core
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = CC20_DOUBLE_ROUNDS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cc20_cmd_t  cmd,
    input  word_t      init_words [CC20_WORDS],
    input  logic [5:0] byte_sel,
    output cc20_stat_t stat,
    output logic [7:0] ks_byte
);

    localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
    localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_ROUND = 2'd1;
    localparam logic [1:0] P_FINAL = 2'd2;

    logic [1:0]      phase_reg, phase_next;
    logic [1:0]      sub_reg, sub_next;
    logic [2:0]      qtr_reg, qtr_next;
    logic [DR_W-1:0] dr_reg, dr_next;
    logic [3:0]      ff_reg, ff_next;
    logic            done_reg, done_next;

    // working state; holds the finished keystream block after feed-forward
    word_t w_reg [CC20_WORDS];

    word_t      add_l, add_r, mix_in, sum, mixed, rot;
    word_t      upd [CC20_WORDS];
    word_t      shifted [CC20_WORDS];
    logic [1:0] sh [4];
    word_t      sel_word;

    // shared unit: one add, one xor and one rotate (by 16, 12, 8 or 7, chosen by the step) per cycle
    always_comb
    begin
        add_l  = w_reg[0];
        add_r  = w_reg[4];
        mix_in = w_reg[12];
        if (phase_reg == P_FINAL)
        begin
            add_r = init_words[ff_reg];
        end
        else if (sub_reg[0])
        begin
            add_l  = w_reg[8];
            add_r  = w_reg[12];
            mix_in = w_reg[4];
        end
        sum   = add_l + add_r;
        mixed = mix_in ^ sum;
        case (sub_reg)
            2'd0:    rot = {mixed[15:0], mixed[31:16]};
            2'd1:    rot = {mixed[19:0], mixed[31:20]};
            2'd2:    rot = {mixed[23:0], mixed[31:24]};
            default: rot = {mixed[24:0], mixed[31:25]};
        endcase
    end

    // column 0 always holds the active quarter; rows rotate to bring the next one in
    always_comb
    begin
        upd = w_reg;
        if (sub_reg[0])
        begin
            upd[8] = sum;
            upd[4] = rot;
        end
        else
        begin
            upd[0]  = sum;
            upd[12] = rot;
        end
        for (int r = 0; r < 4; r++)
        begin
            if (qtr_reg == 3'd3)
            begin
                sh[r] = 2'd1 + 2'(r);      // next column, then diagonalize
            end
            else if (qtr_reg == 3'd7)
            begin
                sh[r] = 2'd1 - 2'(r);      // next column, then undo diagonal
            end
            else
            begin
                sh[r] = 2'd1;
            end
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                shifted[r*4 + j] = upd[{2'(r), 2'(j) + sh[r]}];
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        sub_next   = sub_reg;
        qtr_next   = qtr_reg;
        dr_next    = dr_reg;
        ff_next    = ff_reg;
        done_next  = 1'b0;
        case (phase_reg)
            P_IDLE:
            begin
                if (cmd.load)
                begin
                    phase_next = P_ROUND;
                    sub_next   = '0;
                    qtr_next   = '0;
                    dr_next    = '0;
                end
            end
            P_ROUND:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    qtr_next = qtr_reg + 3'd1;
                    if (qtr_reg == 3'd7)
                    begin
                        if (dr_reg == DR_LAST)
                        begin
                            phase_next = P_FINAL;
                            ff_next    = '0;
                            dr_next    = '0;
                        end
                        else
                        begin
                            dr_next = dr_reg + DR_W'(1);
                        end
                    end
                end
            end
            P_FINAL:
            begin
                ff_next = ff_reg + 4'd1;
                if (ff_reg == 4'd15)
                begin
                    phase_next = P_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            sub_reg   <= '0;
            qtr_reg   <= '0;
            dr_reg    <= '0;
            ff_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            qtr_reg   <= qtr_next;
            dr_reg    <= dr_next;
            ff_reg    <= ff_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == P_IDLE && cmd.load)
        begin
            w_reg <= init_words;
        end
        else if (phase_reg == P_ROUND)
        begin
            w_reg <= (sub_reg == 2'd3) ? shifted : upd;
        end
        else if (phase_reg == P_FINAL)
        begin
            // feed-forward one word a cycle, shifting the block down
            for (int i = 0; i < CC20_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[CC20_WORDS-1] <= sum;
        end
    end

    assign sel_word  = w_reg[byte_sel[5:2]];
    assign ks_byte   = sel_word[{byte_sel[1:0], 3'b000} +: 8];
    assign stat.busy = (phase_reg != P_IDLE);
    assign stat.done = done_reg;

`include "chacha20_stream_cipher_assert.svh"

    `CC20_ASSERT_NOW(a_load_when_idle, cmd.load, phase_reg == P_IDLE, "load while busy")
    `CC20_ASSERT_NEXT(a_load_starts, cmd.load,
        phase_reg == P_ROUND && sub_reg == 2'd0 && qtr_reg == 3'd0 && dr_reg == '0,
        "load did not start rounds")
    `CC20_ASSERT_NOW(a_final_aligned, phase_reg == P_FINAL,
        sub_reg == 2'd0 && qtr_reg == 3'd0, "feed-forward with rows misaligned")

endmodule

### sv/chacha20_stream_cipher.sv
// ChaCha20 stream cipher top level: config registers, word handshake, block sequencing.
// Each input word is one data byte XORed with the next ChaCha20 keystream byte. A byte
// inside a built 64-byte block is accepted, then emitted into the output register. The
// first byte of each block, and any word with restart set, first builds a block: a load,
// the rounds on the single add-xor-rotate unit, the feed-forward and a handoff. in_stall
// is high while a word is in work; a waiting result in the output register does not block
// the next accept.
module chacha20_stream_cipher
    import cc20_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = CC20_DOUBLE_ROUNDS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [63:0] key_reg [4];
    logic [31:0] nonce_first_reg;
    logic [63:0] nonce_upper_reg;
    logic [31:0] start_ctr_reg;

    logic [1:0]  state_reg, state_next;
    logic [6:0]  pos_reg, pos_next;
    logic [31:0] ctr_reg, ctr_next;
    logic [31:0] nonce_reg, nonce_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  data_reg;
    logic [7:0]  out_byte_reg;

    word_t      init_words [CC20_WORDS];
    cc20_cmd_t  cmd;
    cc20_stat_t stat;
    logic [7:0] ks_byte;
    logic       in_take;
    logic       emit;

    assign in_take = in_valid && (state_reg == S_IDLE);
    assign emit    = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            nonce_first_reg <= '0;
            nonce_upper_reg <= '0;
            start_ctr_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY01:       key_reg[0]      <= cfg_data;
                CFG_KEY23:       key_reg[1]      <= cfg_data;
                CFG_KEY45:       key_reg[2]      <= cfg_data;
                CFG_KEY67:       key_reg[3]      <= cfg_data;
                CFG_NONCE_FIRST: nonce_first_reg <= cfg_data[31:0];
                CFG_NONCE_UPPER: nonce_upper_reg <= cfg_data;
                CFG_START_CTR:   start_ctr_reg   <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            init_words[i]       = SIGMA[i];
            init_words[4 + 2*i] = key_reg[i][31:0];
            init_words[5 + 2*i] = key_reg[i][63:32];
        end
        init_words[12] = ctr_reg;
        init_words[13] = nonce_reg;
        init_words[14] = nonce_upper_reg[31:0];
        init_words[15] = nonce_upper_reg[63:32];
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        ctr_next       = ctr_reg;
        nonce_next     = nonce_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        ctr_next   = start_ctr_reg;
                        nonce_next = nonce_first_reg;
                        pos_next   = 7'd64;
                    end
                    state_next = (restart || pos_reg[6]) ? S_LOAD : S_EMIT;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (stat.done)
                begin
                    ctr_next = ctr_reg + 32'd1;
                    // counter wrap carries into nonce word 0
                    if (ctr_reg == '1)
                    begin
                        nonce_next = nonce_reg + 32'd1;
                    end
                    pos_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    pos_next       = pos_reg + 7'd1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= 7'd64;
            ctr_reg       <= '0;
            nonce_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            ctr_reg       <= ctr_next;
            nonce_reg     <= nonce_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            data_reg <= data_byte;
        end
        if (emit)
        begin
            out_byte_reg <= data_reg ^ ks_byte;
        end
    end

    cc20_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .init_words (init_words),
        .byte_sel   (pos_reg[5:0]),
        .stat       (stat),
        .ks_byte    (ks_byte)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

`include "chacha20_stream_cipher_assert.svh"

    `CC20_ASSERT_NEXT(a_restart_builds, in_take && restart, state_reg == S_LOAD,
        "restart word did not build a block")
    `CC20_ASSERT_NOW(a_emit_in_block, state_reg == S_EMIT, !pos_reg[6] && !stat.busy,
        "emit outside a built block")
    `CC20_ASSERT_NOW(a_done_waited, stat.done, state_reg == S_WAIT,
        "block finished while not waiting")

endmodule
